/* src/m4m_pkg.sv */
// m4m_pkg: shared types and constants for the 4x4 fixed-point matrix multiplier
// used by m4m_seq, m4m_mac and mat4_multiply_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package m4m_pkg;

    localparam int VALUE_W = 32;   // Q16.16 element width
    localparam int INDEX_W = 4;    // row-major position field
    localparam int TDATA_W = 40;   // value and index, padded to whole bytes
    localparam int PROD_W  = 2 * VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_seq_state;

    // control that walks down the mac pipeline beside the operands
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

/* src/m4m_ram.sv */
// m4m_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module m4m_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/m4m_mac.sv */
// m4m_mac: shared multiply-accumulate unit with final shift and saturation
// depends on m4m_pkg; operands come from the registered ram read ports
`timescale 1ns / 1ps
`default_nettype none

module m4m_mac #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire m4m_pkg::t_mac_ctl                  i_ctl,
    input  wire logic signed [m4m_pkg::VALUE_W-1:0] i_a,
    input  wire logic signed [m4m_pkg::VALUE_W-1:0] i_b,
    output logic                                    o_done,
    output logic             [m4m_pkg::VALUE_W-1:0] o_value,
    output logic                                    o_sat
);

    localparam int ACC_W = m4m_pkg::PROD_W + $clog2(DIM) + 1;
    localparam int VW    = m4m_pkg::VALUE_W;

    m4m_pkg::t_mac_ctl r_rd_ctl;
    m4m_pkg::t_mac_ctl r_prod_ctl;
    logic signed [m4m_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [ACC_W-1:0]           n_acc;
    logic                              r_done;
    logic [VW-1:0]                     r_value;
    logic                              r_sat;

    logic signed [ACC_W-1:0] w_shifted;
    logic [ACC_W-VW:0]       w_upper;
    logic                    w_in_range;

    // ram read data lines up with the control held in r_rd_ctl
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl   <= '0;
            r_prod_ctl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_rd_ctl   <= i_ctl;
            r_prod_ctl <= r_rd_ctl;
            r_done     <= r_prod_ctl.vld & r_prod_ctl.last;
        end
    end

    always_comb begin
        n_acc = r_prod_ctl.first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_prod_ctl.vld) begin
            r_acc <= n_acc;
        end
    end

    // arithmetic shift floors; the value fits when all bits above 31 match the sign
    assign w_shifted  = r_acc >>> FRAC_BITS;
    assign w_upper    = w_shifted[ACC_W-1:VW-1];
    assign w_in_range = (&w_upper) | ~(|w_upper);

    always_ff @(posedge i_clk) begin
        if (r_done) begin
            r_sat <= ~w_in_range;
            if (w_in_range) begin
                r_value <= w_shifted[VW-1:0];
            end else if (w_shifted[ACC_W-1]) begin
                r_value <= {1'b1, {(VW-1){1'b0}}};
            end else begin
                r_value <= {1'b0, {(VW-1){1'b1}}};
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
    assign o_sat   = r_sat;

endmodule

`default_nettype wire

/* src/m4m_seq.sv */
// m4m_seq: sequencer that walks row, column and k over the shared mac
// depends on m4m_pkg; drives the ram read addresses and the result handshake
`timescale 1ns / 1ps
`default_nettype none

module m4m_seq #(
    parameter int DIM = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_mac_done,
    input  wire logic                          i_out_ready,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    output logic [$clog2(DIM*DIM)-1:0]         o_out_pos,
    output logic                               o_out_last,
    output logic [$clog2(DIM*DIM)-1:0]         o_laddr,
    output logic [$clog2(DIM*DIM)-1:0]         o_raddr,
    output m4m_pkg::t_mac_ctl                  o_ctl
);

    localparam int CW = $clog2(DIM);
    localparam int AW = $clog2(DIM * DIM);

    m4m_pkg::t_seq_state r_state, n_state;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_k, n_k;
    logic [AW-1:0] r_pos, n_pos;

    logic w_k_end;
    logic w_col_end;
    logic w_pos_end;

    assign w_k_end   = (r_k == CW'(DIM - 1));
    assign w_col_end = (r_col == CW'(DIM - 1));
    assign w_pos_end = (r_pos == AW'(DIM * DIM - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            m4m_pkg::S_IDLE: begin
                if (i_start) n_state = m4m_pkg::S_MAC;
            end
            m4m_pkg::S_MAC: begin
                if (w_k_end) n_state = m4m_pkg::S_DRAIN;
            end
            m4m_pkg::S_DRAIN: begin
                if (i_mac_done) n_state = m4m_pkg::S_OUT;
            end
            m4m_pkg::S_OUT: begin
                if (i_out_ready) n_state = w_pos_end ? m4m_pkg::S_IDLE : m4m_pkg::S_MAC;
            end
            default: n_state = m4m_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_k   = r_k;
        n_pos = r_pos;
        unique case (r_state)
            m4m_pkg::S_IDLE: begin
                n_row = '0;
                n_col = '0;
                n_k   = '0;
                n_pos = '0;
            end
            m4m_pkg::S_MAC: begin
                n_k = w_k_end ? '0 : r_k + 1'b1;
            end
            m4m_pkg::S_OUT: begin
                if (i_out_ready && !w_pos_end) begin
                    n_pos = r_pos + 1'b1;
                    if (w_col_end) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == m4m_pkg::S_IDLE);
        o_out_valid  = (r_state == m4m_pkg::S_OUT);
        o_ctl.vld    = (r_state == m4m_pkg::S_MAC);
        o_ctl.first  = (r_k == '0);
        o_ctl.last   = w_k_end;
        o_out_pos    = r_pos;
        o_out_last   = w_pos_end;
        o_laddr      = AW'(32'(r_row) * DIM + 32'(r_k));
        o_raddr      = AW'(32'(r_k) * DIM + 32'(r_col));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= m4m_pkg::S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            r_pos   <= n_pos;
        end
    end

    // the mac finishes an element only while the sequencer waits for it
    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mac_done |-> (r_state == m4m_pkg::S_DRAIN))
        else $error("mac result arrived outside drain");

    // every element starts its k sweep from zero
    a_k_starts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m4m_pkg::S_MAC && $past(r_state) != m4m_pkg::S_MAC) |-> (r_k == '0))
        else $error("k sweep did not start at zero");

    // the final beat of a run returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == m4m_pkg::S_OUT && i_out_ready && w_pos_end)
        |=> (r_state == m4m_pkg::S_IDLE))
        else $error("block not idle after last beat");

    // position advances only when a beat leaves
    a_pos_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != m4m_pkg::S_IDLE && !(r_state == m4m_pkg::S_OUT && i_out_ready))
        |=> $stable(r_pos))
        else $error("position moved without a beat");

endmodule

`default_nettype wire

/* src/mat4_multiply_top.sv */
// mat4_multiply_top: stream wrapper around the operand stores, sequencer and mac
// depends on m4m_pkg, m4m_ram, m4m_mac and m4m_seq
`timescale 1ns / 1ps
`default_nettype none

// Multiplies two DIM x DIM signed Q16.16 matrices held row-major. Each input
// beat writes one element into the left (tuser 0) or right (tuser 1) store;
// a beat with tlast set then starts the product. Both stores are
// undefined after reset, so every entry must be written before a product is
// asked for. The product runs on one shared pipelined 32x32 multiply-accumulate
// unit fed by the stores' registered read ports: each product element is a
// multiply-accumulate sweep over k, a drain of the read, multiply and
// accumulate stages, and an output beat that waits while the output is
// stalled. The input is not ready while a product is in progress. Each sum
// is kept at full width, shifted right by FRAC_BITS rounding toward minus
// infinity and clipped to 32 bits, with tuser flagging a clipped element;
// tlast marks the final element.
module mat4_multiply_top #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // element_value [31:0], element_index [35:32], zero pad [39:36]
    input  wire logic [m4m_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    // matrix_select [0]
    input  wire logic [0:0]                    i_s_axis_tuser,
    // compute_now
    input  wire logic                          i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // product_value [31:0], product_index [35:32], zero pad [39:36]
    output logic [m4m_pkg::TDATA_W-1:0]        o_m_axis_tdata,
    // saturated [0]
    output logic [0:0]                         o_m_axis_tuser,
    // last_of_run
    output logic                               o_m_axis_tlast
);

    localparam int AW = $clog2(DIM * DIM);
    localparam int VW = m4m_pkg::VALUE_W;
    localparam int IW = m4m_pkg::INDEX_W;

    logic                 w_in_beat;
    logic                 w_idx_ok;
    logic [IW-1:0]        w_in_idx;
    logic [VW-1:0]        w_in_value;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_laddr;
    logic [AW-1:0]        w_raddr;
    logic [VW-1:0]        w_ldata;
    logic [VW-1:0]        w_rdata;
    logic [AW-1:0]        w_out_pos;
    logic [VW-1:0]        w_value;
    logic                 w_sat;
    logic                 w_done;
    logic                 w_out_last;
    m4m_pkg::t_mac_ctl    w_ctl;

    assign w_in_beat  = i_s_axis_tvalid & o_s_axis_tready;
    assign w_in_value = i_s_axis_tdata[VW-1:0];
    assign w_in_idx   = i_s_axis_tdata[VW+IW-1:VW];
    // writes past the store are dropped
    assign w_idx_ok   = (32'(w_in_idx) < DIM * DIM);
    assign w_waddr    = AW'(w_in_idx);

    m4m_ram #(
        .WIDTH (VW),
        .DEPTH (DIM * DIM)
    ) u_left_store (
        .i_clk   (i_clk),
        .i_we    (w_in_beat & w_idx_ok & ~i_s_axis_tuser[0]),
        .i_waddr (w_waddr),
        .i_wdata (w_in_value),
        .i_raddr (w_laddr),
        .o_rdata (w_ldata)
    );

    m4m_ram #(
        .WIDTH (VW),
        .DEPTH (DIM * DIM)
    ) u_right_store (
        .i_clk   (i_clk),
        .i_we    (w_in_beat & w_idx_ok & i_s_axis_tuser[0]),
        .i_waddr (w_waddr),
        .i_wdata (w_in_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    m4m_seq #(
        .DIM (DIM)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_beat & i_s_axis_tlast),
        .i_mac_done  (w_done),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_pos   (w_out_pos),
        .o_out_last  (w_out_last),
        .o_laddr     (w_laddr),
        .o_raddr     (w_raddr),
        .o_ctl       (w_ctl)
    );

    m4m_mac #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_ldata),
        .i_b     (w_rdata),
        .o_done  (w_done),
        .o_value (w_value),
        .o_sat   (w_sat)
    );

    assign o_m_axis_tdata = {(m4m_pkg::TDATA_W - VW - IW)'(0), IW'(w_out_pos), w_value};
    assign o_m_axis_tuser = w_sat;
    assign o_m_axis_tlast = w_out_last;

endmodule

`default_nettype wire

/* tb/mat4_multiply_top_test.sv */
// mat4_multiply_top_test: self-checking stream test of the 4x4 Q16.16 matrix multiplier
// depends on m4m_pkg and mat4_multiply_top; predicts every product beat in order
`timescale 1ns / 1ps

module mat4_multiply_top_test;

    localparam int VALUE_W     = m4m_pkg::VALUE_W;
    localparam int INDEX_W     = m4m_pkg::INDEX_W;
    localparam int TDATA_W     = m4m_pkg::TDATA_W;
    localparam int PROD_W      = m4m_pkg::PROD_W;

    localparam int DIM         = 4;
    localparam int FRAC_BITS   = 16;
    localparam int CELLS       = DIM * DIM;
    localparam int ACC_W       = PROD_W + 4;
    localparam int PRODUCT_CYC = CELLS * (DIM + 4);
    localparam int TAIL_CYCLES = 2 * PRODUCT_CYC;
    localparam int STALL_LIMIT = 4000;

    localparam logic [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [VALUE_W-1:0] Q_ONE = VALUE_W'(1) << FRAC_BITS;

    typedef enum logic [0:0] {
        SEL_LEFT  = 1'b0,
        SEL_RIGHT = 1'b1
    } t_matrix_sel;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               sat;
    } t_product;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tready = 1'b0;
    wire logic            s_tready;
    wire logic            m_tvalid;
    wire logic [TDATA_W-1:0] m_tdata;
    wire logic [0:0]      m_tuser;
    wire logic            m_tlast;

    // shadow copies of the operand stores
    logic signed [VALUE_W-1:0] left_matrix  [CELLS];
    logic signed [VALUE_W-1:0] right_matrix [CELLS];

    t_product pending_products [$];
    t_product want_product;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int error_count     = 0;
    int elements_sent   = 0;
    int products_seen   = 0;
    int clipped_seen    = 0;
    int quiet_cycles    = 0;

    mat4_multiply_top #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // full-width sum of products, floor shift, clip to 32 bits
    function automatic void predict_product();
        logic signed [ACC_W-1:0]   acc;
        logic signed [ACC_W-1:0]   scaled;
        logic [ACC_W-VALUE_W:0]    top;
        t_product                  p;
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                acc = '0;
                for (int k = 0; k < DIM; k++) begin
                    acc = acc + left_matrix[r*DIM+k] * right_matrix[k*DIM+c];
                end
                scaled  = acc >>> FRAC_BITS;
                top     = scaled[ACC_W-1:VALUE_W-1];
                p.sat   = !((&top) || (top == '0));
                p.value = p.sat ? (scaled[ACC_W-1] ? Q_MIN : Q_MAX) : scaled[VALUE_W-1:0];
                p.index = INDEX_W'(r * DIM + c);
                p.last  = (r * DIM + c == CELLS - 1);
                pending_products.push_back(p);
            end
        end
    endfunction

    function automatic void store_element(input logic [VALUE_W-1:0] value,
                                          input t_matrix_sel sel,
                                          input logic [INDEX_W-1:0] idx,
                                          input logic compute);
        if (sel == SEL_RIGHT) begin
            right_matrix[idx] = value;
        end else begin
            left_matrix[idx] = value;
        end
        elements_sent++;
        if (compute) begin
            predict_product();
        end
    endfunction

    // mostly moderate magnitudes so that both clipped and exact sums show up
    function automatic logic [VALUE_W-1:0] random_element();
        logic [VALUE_W-1:0] raw;
        int                 width;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return raw;
            1: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return '1;
                    default: return Q_ONE;
                endcase
            end
            default: begin
                width = $urandom_range(1, 22);
                raw   = raw << (VALUE_W - width);
                return $signed(raw) >>> (VALUE_W - width);
            end
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_element(input logic [VALUE_W-1:0] value, input t_matrix_sel sel,
                                input logic [INDEX_W-1:0] idx, input logic compute);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tdata  <= {{(TDATA_W-VALUE_W-INDEX_W){1'b0}}, idx, value};
        s_tuser  <= sel;
        s_tlast  <= compute;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        store_element(value, sel, idx, compute);
        @(negedge i_clk);
    endtask

    // every entry gets written before the first product; right is the identity
    task automatic test_full_load();
        logic [VALUE_W-1:0] left_init [CELLS];
        left_init = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                      32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_8000,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_8001,
                      32'h7FFF_0000, 32'h8001_0000, 32'h0000_8000, 32'hFFFF_FFFE};
        for (int i = 0; i < CELLS; i++) begin
            send_element(left_init[i], SEL_LEFT, INDEX_W'(i), 1'b0);
        end
        for (int i = 0; i < CELLS; i++) begin
            send_element((i % (DIM + 1) == 0) ? Q_ONE : '0, SEL_RIGHT, INDEX_W'(i),
                         i == CELLS - 1);
        end
    endtask

    // huge operands clip high and low in the same product
    task automatic test_saturation();
        send_element(Q_MAX, SEL_RIGHT, INDEX_W'(0), 1'b0);
        send_element(Q_MIN, SEL_RIGHT, INDEX_W'(1), 1'b1);
    endtask

    // tiny negative products must round toward minus infinity
    task automatic test_floor_rounding();
        send_element(32'hFFFF_FFFF, SEL_LEFT, INDEX_W'(15), 1'b0);
        send_element(32'h0000_8000, SEL_RIGHT, INDEX_W'(15), 1'b1);
    endtask

    // plain writes produce nothing until a compute beat arrives
    task automatic test_write_without_compute();
        send_element(32'h0002_0000, SEL_LEFT, INDEX_W'(5), 1'b0);
        send_element(32'hFFFE_0000, SEL_RIGHT, INDEX_W'(10), 1'b0);
        send_element(32'h0000_4000, SEL_LEFT, INDEX_W'(0), 1'b0);
        send_element(32'h0003_0000, SEL_LEFT, INDEX_W'(3), 1'b1);
    endtask

    // runs of random writes closed by a compute, some runs broken or noisy
    task automatic test_random_runs(input int item_count);
        int   sent;
        int   run_len;
        int   shape;
        logic compute;
        sent = 0;
        while (sent < item_count) begin
            run_len = $urandom_range(1, 12);
            shape   = $urandom_range(0, 9);
            for (int n = 0; n < run_len; n++) begin
                if (shape == 0) begin
                    compute = 1'b0;
                end else if (shape == 1) begin
                    compute = ($urandom_range(0, 3) == 0);
                end else begin
                    compute = (n == run_len - 1);
                end
                send_element(random_element(), t_matrix_sel'($urandom_range(0, 1)),
                             INDEX_W'($urandom_range(0, CELLS - 1)), compute);
            end
            sent += run_len;
        end
    endtask

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_products.size() == 0) begin
                $error("product beat with nothing expected, tdata %h", m_tdata);
                error_count++;
            end else begin
                want_product = pending_products.pop_front();
                products_seen++;
                if (m_tuser[0]) begin
                    clipped_seen++;
                end
                if (m_tdata[VALUE_W-1:0] !== want_product.value) begin
                    $error("product_value: expected %h, actual %h",
                           want_product.value, m_tdata[VALUE_W-1:0]);
                    error_count++;
                end
                if (m_tdata[VALUE_W+INDEX_W-1:VALUE_W] !== want_product.index) begin
                    $error("product_index: expected %0d, actual %0d",
                           want_product.index, m_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
                    error_count++;
                end
                if (m_tlast !== want_product.last) begin
                    $error("last_of_run: expected %b, actual %b", want_product.last, m_tlast);
                    error_count++;
                end
                if (m_tuser[0] !== want_product.sat) begin
                    $error("saturated: expected %b, actual %b", want_product.sat, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // no beat on either side for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_full_load();
        test_saturation();
        test_floor_rounding();
        test_write_without_compute();

        send_idle_pct = 24;
        recv_idle_pct = 85;
        test_random_runs(150);
        send_idle_pct = 85;
        recv_idle_pct = 24;
        test_random_runs(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_runs(150);

        s_tvalid <= 1'b0;
        while (pending_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d element beats, checked %0d product beats (%0d clipped)",
                 elements_sent, products_seen, clipped_seen);
        $display("under mixed sender and receiver stalls, then back to back");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
src/m4m_pkg.sv
src/m4m_ram.sv
src/m4m_mac.sv
src/m4m_seq.sv
src/mat4_multiply_top.sv
tb/mat4_multiply_top_test.sv
